FILE: sv/crfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crfp_pkg
// Shared constants, result codes and types for the command/recipe frame parser.
// ----------------------------------------------------------------------------
package crfp_pkg;

    localparam int NAME_CHARS = 15;
    localparam int STEP_COUNT = 8;

    // address and count widths
    localparam int NAME_AW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
    localparam int NAME_PW = $clog2(NAME_CHARS + 1);
    localparam int STEP_AW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
    localparam int STEP_PW = $clog2(STEP_COUNT + 1);
    localparam int CNT_W   = (NAME_AW > STEP_AW) ? NAME_AW : STEP_AW;
    localparam int CMP_W   = (CNT_W > NAME_PW) ? CNT_W : NAME_PW;

    // job queue between parser and result sequencer
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // frame bytes
    localparam logic [7:0] HDR_BYTE   = 8'hAA;
    localparam logic [7:0] START_BYTE = 8'hBB;
    localparam logic [7:0] STOP_BYTE  = 8'hCC;
    localparam logic [7:0] MARK_BYTE  = 8'hFF;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    localparam logic [2:0] CMD_MARK_LEN = 3'd2;
    localparam logic [2:0] END_MARK_LEN = 3'd4;

    // result kinds
    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_STOP  = 2'd1;
    localparam logic [1:0] EV_NAME  = 2'd2;
    localparam logic [1:0] EV_STEP  = 2'd3;

    localparam int IDX_W      = 4;
    localparam int OUT_DATA_W = 48;

    typedef struct packed {
        logic               recipe;
        logic [1:0]         cmd_event;
        logic [NAME_PW-1:0] name_len;
    } job_t;

    typedef struct packed {
        logic [NAME_AW-1:0] name_addr;
        logic [STEP_AW-1:0] step_addr;
    } store_rd_t;

    typedef struct packed {
        logic [7:0]  name_char;
        logic [15:0] volume;
        logic [15:0] duration;
    } store_data_t;

endpackage
`default_nettype wire

FILE: sv/command_recipe_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_recipe_frame_parser
// Deframes start/stop commands and recipe frames from a received byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while s_tready is high. A start or stop command
// gives its single result after its last marker byte, through the job queue
// and the output register. The final marker byte of a recipe launches 23
// results (15 name characters, then 8 steps, tlast on the last step) at one
// per cycle while m_tready is high, all read through the one store read port
// of the result sequencer; from that marker until the last step is in the
// output register, no further byte is taken. Up to two finished jobs wait in
// the queue, so command bytes keep flowing while results wait on m_tready.
// ----------------------------------------------------------------------------
module command_recipe_frame_parser
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [7:0]                         s_tdata,   // [7:0] rx_byte
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [3:0] index, [11:4] name_char, [27:12] volume_raw, [43:28] time_raw, rest zero
    output logic [crfp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [1:0]                         m_tuser,   // [1:0] event_res
    output logic                               m_tlast
);

    logic                   q_full;
    logic                   q_push;
    crfp_pkg::job_t         q_job;
    logic                   q_pop;
    logic                   q_valid;
    crfp_pkg::job_t         q_head;
    logic                   recipe_done;
    crfp_pkg::store_rd_t    rd;
    crfp_pkg::store_data_t  rd_data;

    crfp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_job),
        .recipe_done (recipe_done),
        .rd          (rd),
        .rd_data     (rd_data)
    );

    crfp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    crfp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .recipe_done (recipe_done),
        .rd          (rd),
        .rd_data     (rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

FILE: sv/crfp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crfp_front
// Byte parser: tracks the frame phase, fills the name and step stores and
// posts one job per finished command or recipe frame.
// ----------------------------------------------------------------------------
module crfp_front
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [7:0]             s_tdata,   // [7:0] rx_byte
    input  wire                    q_full,
    output logic                   q_push,
    output crfp_pkg::job_t         q_job,
    input  wire                    recipe_done,
    input  crfp_pkg::store_rd_t    rd,
    output crfp_pkg::store_data_t  rd_data
);

    typedef enum logic [5:0] {
        PH_HDR1    = 6'b000001,
        PH_HDR2    = 6'b000010,
        PH_CMDEND  = 6'b000100,
        PH_NAME    = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_ENDMARK = 6'b100000
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [2:0]                    marker_reg, marker_next;
    logic [1:0]                    cmd_event_reg, cmd_event_next;
    logic [crfp_pkg::NAME_PW-1:0]  name_pos_reg, name_pos_next;
    logic [crfp_pkg::STEP_PW-1:0]  step_pos_reg, step_pos_next;
    logic [1:0]                    byte_cnt_reg, byte_cnt_next;
    logic                          lock_reg, lock_next;
    logic [15:0]                   partial_volume_reg, partial_volume_next;
    logic [7:0]                    partial_time_reg, partial_time_next;

    logic [7:0]  name_store_reg   [crfp_pkg::NAME_CHARS];
    logic [15:0] volume_store_reg [crfp_pkg::STEP_COUNT];
    logic [15:0] time_store_reg   [crfp_pkg::STEP_COUNT];

    logic accept;
    logic name_we;
    logic step_we;

    // a finished recipe holds the stores until the sequencer has read them
    assign s_tready = !q_full && !lock_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        phase_next          = phase_reg;
        marker_next         = marker_reg;
        cmd_event_next      = cmd_event_reg;
        name_pos_next       = name_pos_reg;
        step_pos_next       = step_pos_reg;
        byte_cnt_next       = byte_cnt_reg;
        lock_next           = lock_reg;
        partial_volume_next = partial_volume_reg;
        partial_time_next   = partial_time_reg;
        name_we             = 1'b0;
        step_we             = 1'b0;
        q_push              = 1'b0;
        q_job.recipe        = 1'b0;
        q_job.cmd_event     = cmd_event_reg;
        q_job.name_len      = name_pos_reg;

        if (recipe_done)
        begin
            lock_next = 1'b0;
        end

        if (accept)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    if (s_tdata == crfp_pkg::HDR_BYTE)
                    begin
                        phase_next = PH_HDR2;
                    end
                end
                PH_HDR2:
                begin
                    if (s_tdata == crfp_pkg::START_BYTE || s_tdata == crfp_pkg::STOP_BYTE)
                    begin
                        cmd_event_next = (s_tdata == crfp_pkg::START_BYTE) ?
                                         crfp_pkg::EV_START : crfp_pkg::EV_STOP;
                        marker_next    = crfp_pkg::CMD_MARK_LEN;
                        phase_next     = PH_CMDEND;
                    end
                    else if (s_tdata == crfp_pkg::HDR_BYTE)
                    begin
                        phase_next = PH_NAME;
                    end
                    else
                    begin
                        phase_next    = PH_HDR1;
                        name_pos_next = '0;
                        step_pos_next = '0;
                        byte_cnt_next = '0;
                    end
                end
                PH_CMDEND:
                begin
                    phase_next    = PH_HDR1;
                    name_pos_next = '0;
                    step_pos_next = '0;
                    byte_cnt_next = '0;
                    if (s_tdata == crfp_pkg::MARK_BYTE)
                    begin
                        marker_next = marker_reg - 3'd1;
                        if (marker_reg == 3'd1)
                        begin
                            q_push = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CMDEND;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (name_pos_reg < crfp_pkg::NAME_PW'(crfp_pkg::NAME_CHARS))
                    begin
                        name_we       = 1'b1;
                        name_pos_next = name_pos_reg + crfp_pkg::NAME_PW'(1);
                        if (s_tdata == crfp_pkg::NUL_BYTE)
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    else if (s_tdata == crfp_pkg::NUL_BYTE)
                    begin
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        // name too long: drop the frame
                        phase_next    = PH_HDR1;
                        name_pos_next = '0;
                        step_pos_next = '0;
                        byte_cnt_next = '0;
                    end
                end
                PH_DATA:
                begin
                    byte_cnt_next = byte_cnt_reg + 2'd1;
                    case (byte_cnt_reg)
                        2'd0:    partial_volume_next = {8'h00, s_tdata};
                        2'd1:    partial_volume_next = {s_tdata, partial_volume_reg[7:0]};
                        2'd2:    partial_time_next   = s_tdata;
                        default:
                        begin
                            step_we       = 1'b1;
                            step_pos_next = step_pos_reg + crfp_pkg::STEP_PW'(1);
                            if (step_pos_reg == crfp_pkg::STEP_PW'(crfp_pkg::STEP_COUNT - 1))
                            begin
                                phase_next  = PH_ENDMARK;
                                marker_next = crfp_pkg::END_MARK_LEN;
                            end
                        end
                    endcase
                end
                PH_ENDMARK:
                begin
                    phase_next    = PH_HDR1;
                    name_pos_next = '0;
                    step_pos_next = '0;
                    byte_cnt_next = '0;
                    if (s_tdata == crfp_pkg::MARK_BYTE)
                    begin
                        marker_next = marker_reg - 3'd1;
                        if (marker_reg == 3'd1)
                        begin
                            q_push       = 1'b1;
                            q_job.recipe = 1'b1;
                            lock_next    = 1'b1;
                        end
                        else
                        begin
                            phase_next    = PH_ENDMARK;
                            name_pos_next = name_pos_reg;
                            step_pos_next = step_pos_reg;
                            byte_cnt_next = byte_cnt_reg;
                        end
                    end
                end
                default:
                begin
                    phase_next    = PH_HDR1;
                    name_pos_next = '0;
                    step_pos_next = '0;
                    byte_cnt_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR1;
            marker_reg    <= '0;
            cmd_event_reg <= '0;
            name_pos_reg  <= '0;
            step_pos_reg  <= '0;
            byte_cnt_reg  <= '0;
            lock_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            marker_reg    <= marker_next;
            cmd_event_reg <= cmd_event_next;
            name_pos_reg  <= name_pos_next;
            step_pos_reg  <= step_pos_next;
            byte_cnt_reg  <= byte_cnt_next;
            lock_reg      <= lock_next;
        end
    end

    // entries past the stored name length read back as zero in the sequencer,
    // so the name store needs no clearing
    always_ff @(posedge clk)
    begin
        partial_volume_reg <= partial_volume_next;
        partial_time_reg   <= partial_time_next;
        if (name_we)
        begin
            name_store_reg[name_pos_reg[crfp_pkg::NAME_AW-1:0]] <= s_tdata;
        end
        if (step_we)
        begin
            volume_store_reg[step_pos_reg[crfp_pkg::STEP_AW-1:0]] <= partial_volume_reg;
            time_store_reg[step_pos_reg[crfp_pkg::STEP_AW-1:0]]   <= {s_tdata, partial_time_reg};
        end
    end

    assign rd_data.name_char = name_store_reg[rd.name_addr];
    assign rd_data.volume    = volume_store_reg[rd.step_addr];
    assign rd_data.duration  = time_store_reg[rd.step_addr];

endmodule
`default_nettype wire

FILE: sv/crfp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crfp_queue
// Small job queue that decouples the byte parser from the result sequencer.
// ----------------------------------------------------------------------------
module crfp_queue
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  crfp_pkg::job_t   push_job,
    output logic             full,
    input  wire              pop,
    output logic             valid,
    output crfp_pkg::job_t   head
);

    crfp_pkg::job_t                entry_reg [crfp_pkg::QDEPTH];
    logic [crfp_pkg::QAW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [crfp_pkg::QAW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [crfp_pkg::QCW-1:0]      count_reg, count_next;

    assign full  = (count_reg == crfp_pkg::QCW'(crfp_pkg::QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == crfp_pkg::QAW'(crfp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + crfp_pkg::QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == crfp_pkg::QAW'(crfp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + crfp_pkg::QAW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + crfp_pkg::QCW'(1);
            2'b01:   count_next = count_reg - crfp_pkg::QCW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("job popped from an empty queue");

endmodule
`default_nettype wire

FILE: sv/crfp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crfp_back
// Result sequencer: turns queued jobs into result items, walking the name and
// step stores for a recipe, and holds each result in an output register.
// ----------------------------------------------------------------------------
module crfp_back
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 q_valid,
    input  crfp_pkg::job_t                      q_head,
    output logic                                q_pop,
    output logic                                recipe_done,
    output crfp_pkg::store_rd_t                 rd,
    input  crfp_pkg::store_data_t               rd_data,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [3:0] index, [11:4] name_char, [27:12] volume_raw, [43:28] time_raw, rest zero
    output logic [crfp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [1:0]                          m_tuser,   // [1:0] event_res
    output logic                                m_tlast
);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_NAME = 3'b010,
        BK_STEP = 3'b100
    } back_state_t;

    back_state_t                   state_reg, state_next;
    logic [crfp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [crfp_pkg::NAME_PW-1:0]  name_len_reg, name_len_next;
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    out_event_reg, out_event_next;
    logic [crfp_pkg::IDX_W-1:0]    out_index_reg, out_index_next;
    logic [7:0]                    out_char_reg, out_char_next;
    logic [15:0]                   out_volume_reg, out_volume_next;
    logic [15:0]                   out_time_reg, out_time_next;
    logic                          out_last_reg, out_last_next;

    logic out_free;
    logic step_last;

    assign out_free     = !out_valid_reg || m_tready;
    assign step_last    = (cnt_reg == crfp_pkg::CNT_W'(crfp_pkg::STEP_COUNT - 1));
    assign rd.name_addr = crfp_pkg::NAME_AW'(cnt_reg);
    assign rd.step_addr = crfp_pkg::STEP_AW'(cnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        name_len_next   = name_len_reg;
        out_valid_next  = out_valid_reg;
        out_event_next  = out_event_reg;
        out_index_next  = out_index_reg;
        out_char_next   = out_char_reg;
        out_volume_next = out_volume_reg;
        out_time_next   = out_time_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        recipe_done     = 1'b0;

        if (out_free)
        begin
            out_valid_next  = 1'b0;
            out_index_next  = '0;
            out_char_next   = '0;
            out_volume_next = '0;
            out_time_next   = '0;
            out_last_next   = 1'b0;
            case (state_reg)
                BK_IDLE:
                begin
                    if (q_valid)
                    begin
                        q_pop = 1'b1;
                        if (q_head.recipe)
                        begin
                            state_next    = BK_NAME;
                            cnt_next      = '0;
                            name_len_next = q_head.name_len;
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            out_event_next = q_head.cmd_event;
                            out_last_next  = 1'b1;
                        end
                    end
                end
                BK_NAME:
                begin
                    out_valid_next = 1'b1;
                    out_event_next = crfp_pkg::EV_NAME;
                    out_index_next = crfp_pkg::IDX_W'(cnt_reg);
                    // characters past the stored length read as zero
                    if (crfp_pkg::CMP_W'(cnt_reg) < crfp_pkg::CMP_W'(name_len_reg))
                    begin
                        out_char_next = rd_data.name_char;
                    end
                    if (cnt_reg == crfp_pkg::CNT_W'(crfp_pkg::NAME_CHARS - 1))
                    begin
                        state_next = BK_STEP;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + crfp_pkg::CNT_W'(1);
                    end
                end
                BK_STEP:
                begin
                    out_valid_next  = 1'b1;
                    out_event_next  = crfp_pkg::EV_STEP;
                    out_index_next  = crfp_pkg::IDX_W'(cnt_reg);
                    out_volume_next = rd_data.volume;
                    out_time_next   = rd_data.duration;
                    out_last_next   = step_last;
                    if (step_last)
                    begin
                        state_next  = BK_IDLE;
                        cnt_next    = '0;
                        recipe_done = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + crfp_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    state_next = BK_IDLE;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_len_reg   <= name_len_next;
        out_event_reg  <= out_event_next;
        out_index_reg  <= out_index_next;
        out_char_reg   <= out_char_next;
        out_volume_reg <= out_volume_next;
        out_time_reg   <= out_time_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(crfp_pkg::OUT_DATA_W - crfp_pkg::IDX_W - 40){1'b0}},
                       out_time_reg, out_volume_reg, out_char_reg, out_index_reg};

    a_name_never_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg == crfp_pkg::EV_NAME) |-> !out_last_reg)
        else $error("name character marked as last");

    a_done_on_final_step: assert property (@(posedge clk) disable iff (!rst_n)
        recipe_done |=> (out_valid_reg && out_last_reg && out_event_reg == crfp_pkg::EV_STEP
                         && state_reg == BK_IDLE))
        else $error("recipe released without final step result");

endmodule
`default_nettype wire
